// ----- sv/rlt_pkg.sv -----
// Shared types, codes and constants of the run-length result trace.
package rlt_pkg;

   localparam int RLT_CHANNELS  = 4;
   localparam int RLT_RUN_SLOTS = 8;

   localparam logic [1:0] FUNC_RECORD = 2'd0;
   localparam logic [1:0] FUNC_CLEAR  = 2'd1;
   localparam logic [1:0] FUNC_DUMP   = 2'd2;

   localparam logic [31:0] HASH_BASIS = 32'd2166136261;
   localparam logic [31:0] HASH_MUL   = 32'd16777619;
   localparam logic [31:0] BYTE_MASK  = 32'h0000_00ff;

   typedef struct packed {
      logic [1:0]         func;
      logic [1:0]         channel;
      logic signed [31:0] result_value;
   } req_type;

   typedef struct packed {
      logic [2:0]         run_slot;
      logic signed [31:0] run_value;
      logic [31:0]        run_length;
      logic [31:0]        call_count;
      logic [31:0]        captured_count;
      logic [3:0]         runs_used;
      logic [31:0]        ovf_call_count;
      logic [31:0]        ovf_run_count;
      logic [31:0]        value_hash;
      logic signed [31:0] last_value;
      logic signed [31:0] first_overflow_value;
      logic               last_flag;
   } rsp_type;

endpackage

// ----- sv/rlt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rlt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 write_enable,
   input  logic [ADDR_BITS-1:0] write_address,
   input  logic [WIDTH-1:0]     write_data,
   input  logic                 read_enable,
   input  logic [ADDR_BITS-1:0] read_address,
   output logic [WIDTH-1:0]     read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ----- sv/rlt_fnv_step.sv -----
// One FNV-1a 32 fold step: xor in one byte, then multiply by the prime.
module rlt_fnv_step import rlt_pkg::*; (
   input  logic [31:0] state_hash,
   input  logic [7:0]  data_byte,
   output logic [31:0] next_hash
);

   logic [31:0] mixed;

   assign mixed     = state_hash ^ ({24'd0, data_byte} & BYTE_MASK);
   // Only the low 32 bits of the product are kept, so a 32 by 32 multiply serves.
   assign next_hash = mixed * HASH_MUL;

endmodule

// ----- sv/run_length_result_trace.sv -----
// Top level of the run-length result trace: sequencer, channel summaries, run RAM.
//
// Usage:
// A request is taken at a rising edge with start high and busy low. Its func
// field selects record, clear or dump on one of the trace channels; requests
// with an unknown func or a channel that does not exist are taken and dropped.
// Results appear on rsp_data for one cycle, marked by rsp_strobe; the
// receiver cannot stall them, so it must take every strobed result.
// A record passes through states LOAD, HASH and UPDATE: LOAD loads the channel
// summary and reads the newest run slot, HASH runs the shared FNV byte step
// over the four bytes of the value, and UPDATE updates the state and registers
// the result. A clear writes the reset summary and registers its result from
// the CLEAR state. A dump streams RUN_SLOTS results on consecutive cycles,
// paced by the one read port of the run RAM. busy drops in the cycle of the final
// result, so a new request is taken as soon as the final result is out. Reset
// clears all channels at once; run slots at or above a channel's used count
// read as zero, so the run RAM needs no clearing pass.
module run_length_result_trace import rlt_pkg::*; #(
   parameter int CHANNELS  = RLT_CHANNELS,
   parameter int RUN_SLOTS = RLT_RUN_SLOTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_BITS = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
   localparam int USED_BITS = $clog2(RUN_SLOTS + 1);
   localparam int RAM_DEPTH = CHANNELS * (2 ** SLOT_BITS);
   localparam int RAM_ABITS = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(RUN_SLOTS - 1);
   localparam logic [USED_BITS-1:0] FULL_USED = USED_BITS'(RUN_SLOTS);

   typedef struct packed {
      logic [31:0]          calls;
      logic [31:0]          captured;
      logic [USED_BITS-1:0] used;
      logic [31:0]          ov_calls;
      logic [31:0]          ov_runs;
      logic [31:0]          hash;
      logic [31:0]          last;
      logic [31:0]          first_ov;
      logic [31:0]          ov_last;
   } chan_type;

   localparam chan_type CHAN_RESET = '{hash: HASH_BASIS, default: '0};

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_HASH, ST_UPDATE, ST_CLEAR, ST_DUMP, ST_DRAIN
   } state_type;

   state_type            state_ff, state_in;
   logic [CH_BITS-1:0]   ch_ff, ch_in;
   logic [31:0]          value_ff, value_in;
   logic [31:0]          hash_ff, hash_in;
   logic [1:0]           step_ff, step_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic                 em_valid_ff, em_valid_in;
   logic [SLOT_BITS-1:0] em_slot_ff, em_slot_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   chan_type             chan_ff [CHANNELS];
   chan_type             chan_in;
   chan_type             cur;
   logic                 chan_we;

   logic [CH_BITS+1:0]   req_ch_wide;
   logic                 chan_ok;
   logic [7:0]           hash_byte;
   logic [31:0]          step_hash;

   logic                 ram_re, ram_we;
   logic [SLOT_BITS-1:0] ram_rslot, ram_wslot;
   logic [CH_BITS+SLOT_BITS-1:0] ram_raddr_wide, ram_waddr_wide;
   logic [63:0]          ram_wdata, ram_rdata;
   logic [31:0]          rd_value, rd_length;
   logic [USED_BITS-1:0] used_m1;

   function automatic rsp_type summary(chan_type c, logic [2:0] slot, logic [31:0] val,
                                       logic [31:0] len, logic last);
      rsp_type               r;
      logic [USED_BITS+3:0]  used_wide;
      used_wide              = {4'd0, c.used};
      r.run_slot             = slot;
      r.run_value            = val;
      r.run_length           = len;
      r.call_count           = c.calls;
      r.captured_count       = c.captured;
      r.runs_used            = used_wide[3:0];
      r.ovf_call_count       = c.ov_calls;
      r.ovf_run_count        = c.ov_runs;
      r.value_hash           = c.hash;
      r.last_value           = c.last;
      r.first_overflow_value = c.first_ov;
      r.last_flag            = last;
      return r;
   endfunction

   assign req_ch_wide = {{CH_BITS{1'b0}}, req_data.channel};
   assign chan_ok     = ({3'b000, req_data.channel} < 5'(CHANNELS));
   assign cur         = chan_ff[ch_ff];
   assign hash_byte   = 8'(value_ff >> {step_ff, 3'b000});
   assign rd_value    = ram_rdata[63:32];
   assign rd_length   = ram_rdata[31:0];
   assign used_m1     = cur.used - USED_BITS'(1);

   rlt_fnv_step u_fnv_step (
      .state_hash (hash_ff),
      .data_byte  (hash_byte),
      .next_hash  (step_hash)
   );

   assign ram_raddr_wide = {ch_ff, ram_rslot};
   assign ram_waddr_wide = {ch_ff, ram_wslot};

   rlt_ram #(
      .WIDTH (64),
      .DEPTH (RAM_DEPTH)
   ) u_run_ram (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr_wide[RAM_ABITS-1:0]),
      .write_data    (ram_wdata),
      .read_enable   (ram_re),
      .read_address  (ram_raddr_wide[RAM_ABITS-1:0]),
      .read_data     (ram_rdata)
   );

   always_comb begin
      logic [SLOT_BITS+2:0] slot_wide;
      state_in      = state_ff;
      ch_in         = ch_ff;
      value_in      = value_ff;
      hash_in       = hash_ff;
      step_in       = step_ff;
      slot_in       = slot_ff;
      em_valid_in   = 1'b0;
      em_slot_in    = em_slot_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ram_re        = 1'b0;
      ram_rslot     = slot_ff;
      ram_we        = 1'b0;
      ram_wslot     = used_m1[SLOT_BITS-1:0];
      ram_wdata     = {value_ff, rd_length + 32'd1};
      chan_we       = 1'b0;
      chan_in       = cur;
      slot_wide     = {3'b000, em_slot_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ch_in    = req_ch_wide[CH_BITS-1:0];
               value_in = req_data.result_value;
               slot_in  = '0;
               if (chan_ok) begin
                  case (req_data.func)
                     FUNC_RECORD: state_in = ST_LOAD;
                     FUNC_CLEAR:  state_in = ST_CLEAR;
                     FUNC_DUMP:   state_in = ST_DUMP;
                     default:     state_in = ST_IDLE;
                  endcase
               end
            end
         end
         ST_LOAD: begin
            // Fetch the newest run slot while the hash steps run.
            hash_in   = cur.hash;
            step_in   = 2'd0;
            ram_re    = 1'b1;
            ram_rslot = used_m1[SLOT_BITS-1:0];
            state_in  = ST_HASH;
         end
         ST_HASH: begin
            hash_in = step_hash;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            chan_we       = 1'b1;
            chan_in.calls = cur.calls + 32'd1;
            chan_in.last  = value_ff;
            chan_in.hash  = hash_ff;
            if (cur.ov_calls != 32'd0) begin
               chan_in.ov_calls = cur.ov_calls + 32'd1;
               if (value_ff != cur.ov_last) begin
                  chan_in.ov_runs = cur.ov_runs + 32'd1;
               end
               chan_in.ov_last = value_ff;
            end else if (cur.used != '0 && rd_value == value_ff) begin
               ram_we           = 1'b1;
               chan_in.captured = cur.captured + 32'd1;
            end else if (cur.used < FULL_USED) begin
               ram_we           = 1'b1;
               ram_wslot        = cur.used[SLOT_BITS-1:0];
               ram_wdata        = {value_ff, 32'd1};
               chan_in.used     = cur.used + USED_BITS'(1);
               chan_in.captured = cur.captured + 32'd1;
            end else begin
               chan_in.ov_calls = 32'd1;
               chan_in.ov_runs  = 32'd1;
               chan_in.first_ov = value_ff;
               chan_in.ov_last  = value_ff;
            end
            rsp_strobe_in = 1'b1;
            rsp_in        = summary(chan_in, 3'd0, 32'd0, 32'd0, 1'b1);
            state_in      = ST_IDLE;
         end
         ST_CLEAR: begin
            chan_we       = 1'b1;
            chan_in       = CHAN_RESET;
            rsp_strobe_in = 1'b1;
            rsp_in        = summary(CHAN_RESET, 3'd0, 32'd0, 32'd0, 1'b1);
            state_in      = ST_IDLE;
         end
         ST_DUMP: begin
            ram_re      = 1'b1;
            em_valid_in = 1'b1;
            em_slot_in  = slot_ff;
            slot_in     = slot_ff + SLOT_BITS'(1);
            if (slot_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Read data for a dumped slot arrives in the cycle after its read.
      // Slots the channel has not filled yet are reported as zero, whatever the RAM holds.
      if (em_valid_ff) begin
         rsp_strobe_in = 1'b1;
         if (USED_BITS'(em_slot_ff) < cur.used) begin
            rsp_in = summary(cur, slot_wide[2:0], rd_value, rd_length,
                             em_slot_ff == LAST_SLOT);
         end else begin
            rsp_in = summary(cur, slot_wide[2:0], 32'd0, 32'd0,
                             em_slot_ff == LAST_SLOT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         em_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         em_valid_ff   <= em_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      ch_ff      <= ch_in;
      value_ff   <= value_in;
      hash_ff    <= hash_in;
      step_ff    <= step_in;
      slot_ff    <= slot_in;
      em_slot_ff <= em_slot_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            chan_ff[i] <= CHAN_RESET;
         end
      end else if (chan_we) begin
         chan_ff[ch_ff] <= chan_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef NO_ASSERTIONS
   a_record_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && chan_ok && req_data.func == FUNC_RECORD |-> ##7 rsp_strobe)
      else $error("record result did not appear seven cycles after the request");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && chan_ok && req_data.func == FUNC_CLEAR |-> ##2
      (rsp_strobe && rsp_data.call_count == 32'd0 && rsp_data.value_hash == HASH_BASIS))
      else $error("clear result missing or not in reset state");

   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_flag |=> rsp_strobe)
      else $error("dump results are not on consecutive cycles");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_flag |=> !rsp_strobe)
      else $error("result strobe directly after a final result");
`endif

endmodule
